// ----- src/pes_pkg.sv -----
// shared types, codes and constants of the parking exit sequencer
package pes_pkg;

  // operation codes
  localparam logic [1:0] OP_RANGE = 2'd0;
  localparam logic [1:0] OP_SPEED = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  // steer commands
  localparam logic [1:0] T_STRAIGHT = 2'd0;
  localparam logic [1:0] T_LEFT     = 2'd1;
  localparam logic [1:0] T_RIGHT    = 2'd2;

  // phases
  localparam logic [2:0] PH_0    = 3'd0;
  localparam logic [2:0] PH_1    = 3'd1;
  localparam logic [2:0] PH_2    = 3'd2;
  localparam logic [2:0] PH_3    = 3'd3;
  localparam logic [2:0] PH_IDLE = 3'd4;

  // space kinds
  localparam logic [2:0] KIND_LEFT_PERP  = 3'd0;
  localparam logic [2:0] KIND_LEFT_PAR   = 3'd1;
  localparam logic [2:0] KIND_RIGHT_PERP = 3'd2;
  localparam logic [2:0] KIND_RIGHT_PAR  = 3'd3;
  localparam logic [2:0] KIND_UNKNOWN    = 3'd4;

  // register indexes
  localparam int          CFG_ADDR_W             = 3;
  localparam logic [2:0]  CFG_SPACE_KIND         = 3'd0;
  localparam logic [2:0]  CFG_FORWARD_SPEED      = 3'd1;
  localparam logic [2:0]  CFG_BACKWARD_SPEED     = 3'd2;
  localparam logic [2:0]  CFG_EXIT_DISTANCE      = 3'd3;
  localparam logic [2:0]  CFG_SEARCH_DISTANCE    = 3'd4;
  localparam logic [2:0]  CFG_BRAKE_DISTANCE     = 3'd5;
  localparam logic [2:0]  CFG_PARALLEL_CLEARANCE = 3'd6;
  localparam logic [2:0]  CFG_SPACE_LENGTH       = 3'd7;

  // sensor indexes
  localparam int         NUM_SENSORS  = 12;
  localparam logic [3:0] SENSOR_LIMIT = 4'd12;
  localparam logic [3:0] S_LF  = 4'd0;
  localparam logic [3:0] S_LB  = 4'd1;
  localparam logic [3:0] S_RF  = 4'd2;
  localparam logic [3:0] S_RB  = 4'd3;
  localparam logic [3:0] S_FL  = 4'd4;
  localparam logic [3:0] S_FCL = 4'd5;
  localparam logic [3:0] S_FCR = 4'd6;
  localparam logic [3:0] S_FR  = 4'd7;
  localparam logic [3:0] S_BL  = 4'd8;
  localparam logic [3:0] S_BCL = 4'd9;
  localparam logic [3:0] S_BCR = 4'd10;
  localparam logic [3:0] S_BR  = 4'd11;

  // fixed thresholds
  localparam logic [15:0] SPACE_WIDTH_MM  = 16'd2500;
  localparam logic [15:0] MIN_SIDE_GAP_MM = 16'd300;

  // register reset values
  localparam logic [2:0]         RST_SPACE_KIND         = KIND_UNKNOWN;
  localparam logic signed [15:0] RST_FORWARD_SPEED      = 16'sd300;
  localparam logic signed [15:0] RST_BACKWARD_SPEED     = -16'sd300;
  localparam logic [15:0]        RST_EXIT_DISTANCE      = 16'd2500;
  localparam logic [15:0]        RST_SEARCH_DISTANCE    = 16'd1500;
  localparam logic [15:0]        RST_BRAKE_DISTANCE     = 16'd300;
  localparam logic [15:0]        RST_PARALLEL_CLEARANCE = 16'd500;
  localparam logic [15:0]        RST_SPACE_LENGTH       = 16'd6000;

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         sensor_sel;
    logic [15:0]        range_mm;
    logic signed [15:0] speed_mm_s;
    logic [15:0]        elapsed_ticks;
  } item_t;

  typedef struct packed {
    logic [1:0]         turn_cmd;
    logic signed [15:0] move_cmd;
    logic [2:0]         phase;
    logic               done_res;
    logic               bad_space;
  } res_t;

  typedef struct packed {
    logic [2:0]         space_kind;
    logic signed [15:0] forward_speed;
    logic signed [15:0] backward_speed;
    logic [15:0]        exit_distance;
    logic [15:0]        search_distance;
    logic [15:0]        brake_distance;
    logic [15:0]        parallel_clearance;
    logic [15:0]        space_length;
  } cfg_t;

endpackage

// ----- src/pes_cfg.sv -----
// configuration register bank
module pes_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pes_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [15:0]                     cfg_data,
  output pes_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.space_kind         <= pes_pkg::RST_SPACE_KIND;
      cfg.forward_speed      <= pes_pkg::RST_FORWARD_SPEED;
      cfg.backward_speed     <= pes_pkg::RST_BACKWARD_SPEED;
      cfg.exit_distance      <= pes_pkg::RST_EXIT_DISTANCE;
      cfg.search_distance    <= pes_pkg::RST_SEARCH_DISTANCE;
      cfg.brake_distance     <= pes_pkg::RST_BRAKE_DISTANCE;
      cfg.parallel_clearance <= pes_pkg::RST_PARALLEL_CLEARANCE;
      cfg.space_length       <= pes_pkg::RST_SPACE_LENGTH;
    end else if (cfg_we) begin
      case (cfg_addr)
        pes_pkg::CFG_SPACE_KIND:         cfg.space_kind         <= cfg_data[2:0];
        pes_pkg::CFG_FORWARD_SPEED:      cfg.forward_speed      <= cfg_data;
        pes_pkg::CFG_BACKWARD_SPEED:     cfg.backward_speed     <= cfg_data;
        pes_pkg::CFG_EXIT_DISTANCE:      cfg.exit_distance      <= cfg_data;
        pes_pkg::CFG_SEARCH_DISTANCE:    cfg.search_distance    <= cfg_data;
        pes_pkg::CFG_BRAKE_DISTANCE:     cfg.brake_distance     <= cfg_data;
        pes_pkg::CFG_PARALLEL_CLEARANCE: cfg.parallel_clearance <= cfg_data;
        pes_pkg::CFG_SPACE_LENGTH:       cfg.space_length       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- src/pes_step.sv -----
// sequencer state and the single-pass update for one beat
module pes_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           commit,
  input  pes_pkg::item_t item,
  input  pes_pkg::cfg_t  cfg,
  output pes_pkg::res_t  res
);

  logic [15:0]        range_store [pes_pkg::NUM_SENSORS];
  logic signed [31:0] travelled_mm;
  logic [2:0]         phase_reg;
  logic [1:0]         turn_reg;
  logic signed [15:0] move_reg;

  logic signed [31:0] travelled_mm_next;
  logic [2:0]         phase_reg_next;
  logic [1:0]         turn_reg_next;
  logic signed [15:0] move_reg_next;
  logic               done;
  logic               bad;

  // speed sample: floor(speed * elapsed / 1024) with saturating accumulate
  logic signed [32:0] prod;
  logic signed [32:0] inc;
  logic signed [33:0] sum;
  logic signed [31:0] sat_sum;

  assign prod = 33'(item.speed_mm_s * $signed({1'b0, item.elapsed_ticks}));
  assign inc  = prod >>> 10;
  assign sum  = {{2{travelled_mm[31]}}, travelled_mm} + {inc[32], inc};

  always_comb begin
    if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
      sat_sum = sum[31:0];
    end else if (sum[33]) begin
      sat_sum = {1'b1, 31'd0};
    end else begin
      sat_sum = {1'b0, {31{1'b1}}};
    end
  end

  // side-dependent sensor taps
  logic        left;
  logic [1:0]  side;
  logic [1:0]  other;
  logic [15:0] far_rear, near_front, near_rear;
  logic [15:0] front_c, side_f, corner_f, corner_b, centre_b, guard;

  assign left       = ~cfg.space_kind[1];
  assign side       = left ? pes_pkg::T_LEFT : pes_pkg::T_RIGHT;
  assign other      = left ? pes_pkg::T_RIGHT : pes_pkg::T_LEFT;
  assign far_rear   = left ? range_store[pes_pkg::S_RB] : range_store[pes_pkg::S_LB];
  assign near_front = left ? range_store[pes_pkg::S_LF] : range_store[pes_pkg::S_RF];
  assign near_rear  = left ? range_store[pes_pkg::S_LB] : range_store[pes_pkg::S_RB];
  assign front_c    = left ? range_store[pes_pkg::S_FCR] : range_store[pes_pkg::S_FCL];
  assign side_f     = left ? range_store[pes_pkg::S_LF] : range_store[pes_pkg::S_RF];
  assign corner_f   = left ? range_store[pes_pkg::S_FL] : range_store[pes_pkg::S_FR];
  assign corner_b   = left ? range_store[pes_pkg::S_BL] : range_store[pes_pkg::S_BR];
  assign centre_b   = left ? range_store[pes_pkg::S_BCL] : range_store[pes_pkg::S_BCR];
  assign guard      = left ? range_store[pes_pkg::S_FL] : range_store[pes_pkg::S_RF];

  logic past_exit;
  logic rear_close;
  logic half_passed;

  assign past_exit  = travelled_mm > $signed({16'd0, cfg.exit_distance});
  assign rear_close = range_store[pes_pkg::S_BL]  < cfg.brake_distance
                   || range_store[pes_pkg::S_BCL] < cfg.brake_distance
                   || range_store[pes_pkg::S_BCR] < cfg.brake_distance
                   || range_store[pes_pkg::S_BR]  < cfg.brake_distance;
  assign half_passed = {centre_b, 1'b0} > {1'b0, cfg.space_length};

  always_comb begin
    travelled_mm_next = travelled_mm;
    phase_reg_next    = phase_reg;
    turn_reg_next     = turn_reg;
    move_reg_next     = move_reg;
    done              = 1'b0;
    bad               = 1'b0;
    case (item.op)
      pes_pkg::OP_SPEED: begin
        travelled_mm_next = sat_sum;
      end
      pes_pkg::OP_START: begin
        travelled_mm_next = '0;
        turn_reg_next     = pes_pkg::T_STRAIGHT;
        if (cfg.space_kind == pes_pkg::KIND_LEFT_PERP
            || cfg.space_kind == pes_pkg::KIND_RIGHT_PERP) begin
          phase_reg_next = pes_pkg::PH_0;
          move_reg_next  = cfg.forward_speed;
        end else if (cfg.space_kind == pes_pkg::KIND_LEFT_PAR
                     || cfg.space_kind == pes_pkg::KIND_RIGHT_PAR) begin
          phase_reg_next = pes_pkg::PH_0;
          move_reg_next  = cfg.backward_speed;
        end else begin
          phase_reg_next = pes_pkg::PH_IDLE;
          move_reg_next  = '0;
          bad            = 1'b1;
        end
      end
      pes_pkg::OP_TICK: begin
        if (phase_reg < pes_pkg::PH_IDLE && !cfg.space_kind[2]) begin
          if (!cfg.space_kind[0]) begin
            // perpendicular exit
            case (phase_reg)
              pes_pkg::PH_0: begin
                if (past_exit) begin
                  turn_reg_next  = side;
                  phase_reg_next = pes_pkg::PH_1;
                end
              end
              pes_pkg::PH_1: begin
                if (far_rear > cfg.search_distance) begin
                  phase_reg_next = pes_pkg::PH_2;
                end
              end
              pes_pkg::PH_2: begin
                if (near_front < cfg.search_distance
                    || (range_store[pes_pkg::S_BCL] > pes_pkg::SPACE_WIDTH_MM
                        && range_store[pes_pkg::S_BCR] > pes_pkg::SPACE_WIDTH_MM)) begin
                  move_reg_next  = '0;
                  turn_reg_next  = pes_pkg::T_STRAIGHT;
                  phase_reg_next = pes_pkg::PH_IDLE;
                  done           = 1'b1;
                end else begin
                  turn_reg_next = (near_rear < cfg.brake_distance) ? pes_pkg::T_STRAIGHT
                                                                   : side;
                end
              end
              default: begin
                // phase 3 left over from a parallel exit
                phase_reg_next = pes_pkg::PH_IDLE;
              end
            endcase
          end else begin
            // parallel exit
            case (phase_reg)
              pes_pkg::PH_0: begin
                if (front_c > cfg.parallel_clearance || rear_close) begin
                  turn_reg_next  = other;
                  move_reg_next  = cfg.forward_speed;
                  phase_reg_next = pes_pkg::PH_1;
                end
              end
              pes_pkg::PH_1: begin
                if (side_f > cfg.search_distance && corner_f > cfg.search_distance) begin
                  turn_reg_next  = pes_pkg::T_STRAIGHT;
                  move_reg_next  = cfg.forward_speed;
                  phase_reg_next = pes_pkg::PH_2;
                end else if (corner_f < cfg.brake_distance) begin
                  if (corner_b < cfg.brake_distance) begin
                    turn_reg_next = other;
                    move_reg_next = cfg.forward_speed;
                  end else begin
                    turn_reg_next = side;
                    move_reg_next = cfg.backward_speed;
                  end
                end
              end
              pes_pkg::PH_2: begin
                if (half_passed) begin
                  turn_reg_next  = side;
                  move_reg_next  = cfg.forward_speed;
                  phase_reg_next = pes_pkg::PH_3;
                end
              end
              default: begin
                if (corner_b > cfg.space_length) begin
                  move_reg_next  = '0;
                  turn_reg_next  = pes_pkg::T_STRAIGHT;
                  phase_reg_next = pes_pkg::PH_IDLE;
                  done           = 1'b1;
                end else if (guard < pes_pkg::MIN_SIDE_GAP_MM) begin
                  turn_reg_next = pes_pkg::T_STRAIGHT;
                end
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pes_pkg::NUM_SENSORS; i++) begin
        range_store[i] <= '0;
      end
      travelled_mm <= '0;
      phase_reg    <= pes_pkg::PH_IDLE;
      turn_reg     <= pes_pkg::T_STRAIGHT;
      move_reg     <= '0;
    end else if (commit) begin
      if (item.op == pes_pkg::OP_RANGE && item.sensor_sel < pes_pkg::SENSOR_LIMIT) begin
        range_store[item.sensor_sel] <= item.range_mm;
      end
      travelled_mm <= travelled_mm_next;
      phase_reg    <= phase_reg_next;
      turn_reg     <= turn_reg_next;
      move_reg     <= move_reg_next;
    end
  end

  assign res.turn_cmd  = turn_reg_next;
  assign res.move_cmd  = move_reg_next;
  assign res.phase     = phase_reg_next;
  assign res.done_res  = done;
  assign res.bad_space = bad;

endmodule

// ----- src/parking_exit_sequencer_core.sv -----
// top level: input register, sequencer update, result register
// Parking exit sequencer. One result beat for every input beat, in order. The block
// takes a new beat every cycle as long as the result side keeps up; a beat waits in the
// input register, its update of ranges, distance and phase is done in one pass of logic
// and written together with its result into the result register when the beat leaves
// the input register. The whole update (one 16x17 multiply with saturating add, the
// threshold compares and the phase step) lies between the input and result registers.
// Registers are written through cfg_we, cfg_addr and cfg_data; the user must write them
// only while no beat is in flight, the block itself does not enforce this.
module parking_exit_sequencer_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  pes_pkg::item_t                  item,
  output logic                            res_valid,
  input  logic                            res_stall,
  output pes_pkg::res_t                   res,
  input  logic                            cfg_we,
  input  logic [pes_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [15:0]                     cfg_data
);

  pes_pkg::cfg_t  cfg;
  pes_pkg::item_t item_q;
  pes_pkg::res_t  step_res;
  logic           item_q_valid;
  logic           advance;

  // the held beat moves on when the result register is free or being emptied
  assign advance    = item_q_valid && (!res_valid || !res_stall);
  assign item_stall = item_q_valid && !advance;

  pes_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  pes_step u_step (
    .clk    (clk),
    .rst    (rst),
    .commit (advance),
    .item   (item_q),
    .cfg    (cfg),
    .res    (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (!item_stall) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= step_res;
    end
  end

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> item_q_valid && res_valid)
    else $error("input stalled without a held beat");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.done_res |-> res.phase == pes_pkg::PH_IDLE && res.move_cmd == '0
                                  && !res.bad_space)
    else $error("finishing beat not idle with stopped move");

  a_bad_start_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.bad_space |-> res.phase == pes_pkg::PH_IDLE && res.move_cmd == '0
                                   && res.turn_cmd == pes_pkg::T_STRAIGHT)
    else $error("bad start did not go idle");

  a_step_loads_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("committed beat produced no result");
`endif

endmodule

// ----- bench/tb_top.sv -----
// self-checking bench for the parking exit sequencer: directed, saturation and random exits
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ODO_MAX = 2147483647;
  localparam longint ODO_MIN = -ODO_MAX - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  pes_pkg::item_t item = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  pes_pkg::res_t res;
  logic cfg_we = 1'b0;
  logic [pes_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [15:0] cfg_data = '0;

  parking_exit_sequencer_core u_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mirror of the sequencer state and its registers
  pes_pkg::cfg_t      regs;
  logic [15:0]        ranges [pes_pkg::NUM_SENSORS];
  logic signed [31:0] odometer;
  logic [2:0]         ph_now;
  logic [1:0]         steer_now;
  logic signed [15:0] move_now;

  pes_pkg::res_t pending_cmds [$];
  pes_pkg::res_t oldest_cmd;
  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned exits_done = 0;
  int unsigned starts_refused = 0;
  logic calm = 1'b0;
  int unsigned stall_hold = 0;

  function automatic void perp_tick(input logic left, inout logic fin);
    logic [1:0] side;
    logic [3:0] far_rear, near_front, near_rear;
    side = left ? pes_pkg::T_LEFT : pes_pkg::T_RIGHT;
    far_rear = left ? pes_pkg::S_RB : pes_pkg::S_LB;
    near_front = left ? pes_pkg::S_LF : pes_pkg::S_RF;
    near_rear = left ? pes_pkg::S_LB : pes_pkg::S_RB;
    case (ph_now)
      pes_pkg::PH_0: begin
        if (longint'(odometer) > longint'(regs.exit_distance)) begin
          steer_now = side;
          ph_now = pes_pkg::PH_1;
        end
      end
      pes_pkg::PH_1: begin
        if (ranges[far_rear] > regs.search_distance) ph_now = pes_pkg::PH_2;
      end
      pes_pkg::PH_2: begin
        if (ranges[near_front] < regs.search_distance ||
            (ranges[pes_pkg::S_BCL] > pes_pkg::SPACE_WIDTH_MM &&
             ranges[pes_pkg::S_BCR] > pes_pkg::SPACE_WIDTH_MM)) begin
          move_now = '0;
          steer_now = pes_pkg::T_STRAIGHT;
          ph_now = pes_pkg::PH_IDLE;
          fin = 1'b1;
        end else begin
          steer_now = (ranges[near_rear] < regs.brake_distance) ? pes_pkg::T_STRAIGHT
                                                                 : side;
        end
      end
      // a parallel-only phase left over after the kind was switched
      default: ph_now = pes_pkg::PH_IDLE;
    endcase
  endfunction

  function automatic void par_tick(input logic left, inout logic fin);
    logic [1:0] side, other;
    logic [3:0] front_c, side_f, corner_f, corner_b, centre_b, guard;
    side = left ? pes_pkg::T_LEFT : pes_pkg::T_RIGHT;
    other = left ? pes_pkg::T_RIGHT : pes_pkg::T_LEFT;
    front_c = left ? pes_pkg::S_FCR : pes_pkg::S_FCL;
    side_f = left ? pes_pkg::S_LF : pes_pkg::S_RF;
    corner_f = left ? pes_pkg::S_FL : pes_pkg::S_FR;
    corner_b = left ? pes_pkg::S_BL : pes_pkg::S_BR;
    centre_b = left ? pes_pkg::S_BCL : pes_pkg::S_BCR;
    guard = left ? pes_pkg::S_FL : pes_pkg::S_RF;
    case (ph_now)
      pes_pkg::PH_0: begin
        if (ranges[front_c] > regs.parallel_clearance ||
            ranges[pes_pkg::S_BL] < regs.brake_distance ||
            ranges[pes_pkg::S_BCL] < regs.brake_distance ||
            ranges[pes_pkg::S_BCR] < regs.brake_distance ||
            ranges[pes_pkg::S_BR] < regs.brake_distance) begin
          steer_now = other;
          move_now = regs.forward_speed;
          ph_now = pes_pkg::PH_1;
        end
      end
      pes_pkg::PH_1: begin
        if (ranges[side_f] > regs.search_distance &&
            ranges[corner_f] > regs.search_distance) begin
          steer_now = pes_pkg::T_STRAIGHT;
          move_now = regs.forward_speed;
          ph_now = pes_pkg::PH_2;
        end else if (ranges[corner_f] < regs.brake_distance) begin
          if (ranges[corner_b] < regs.brake_distance) begin
            steer_now = other;
            move_now = regs.forward_speed;
          end else begin
            steer_now = side;
            move_now = regs.backward_speed;
          end
        end
      end
      pes_pkg::PH_2: begin
        // half the space length, compared without losing the low bit
        if ({ranges[centre_b], 1'b0} > {1'b0, regs.space_length}) begin
          steer_now = side;
          move_now = regs.forward_speed;
          ph_now = pes_pkg::PH_3;
        end
      end
      default: begin
        if (ranges[corner_b] > regs.space_length) begin
          move_now = '0;
          steer_now = pes_pkg::T_STRAIGHT;
          ph_now = pes_pkg::PH_IDLE;
          fin = 1'b1;
        end else if (ranges[guard] < pes_pkg::MIN_SIDE_GAP_MM) begin
          steer_now = pes_pkg::T_STRAIGHT;
        end
      end
    endcase
  endfunction

  function automatic pes_pkg::res_t advance_sequencer(input pes_pkg::item_t it);
    pes_pkg::res_t r;
    longint prod, total;
    logic fin, refused;
    fin = 1'b0;
    refused = 1'b0;
    case (it.op)
      pes_pkg::OP_RANGE: begin
        if (it.sensor_sel < pes_pkg::SENSOR_LIMIT) ranges[it.sensor_sel] = it.range_mm;
      end
      pes_pkg::OP_SPEED: begin
        prod = longint'(it.speed_mm_s) * longint'(it.elapsed_ticks);
        // arithmetic shift rounds toward minus infinity
        total = longint'(odometer) + (prod >>> 10);
        if (total > ODO_MAX) total = ODO_MAX;
        if (total < ODO_MIN) total = ODO_MIN;
        odometer = 32'(total);
      end
      pes_pkg::OP_START: begin
        odometer = '0;
        steer_now = pes_pkg::T_STRAIGHT;
        case (regs.space_kind)
          pes_pkg::KIND_LEFT_PERP, pes_pkg::KIND_RIGHT_PERP: begin
            ph_now = pes_pkg::PH_0;
            move_now = regs.forward_speed;
          end
          pes_pkg::KIND_LEFT_PAR, pes_pkg::KIND_RIGHT_PAR: begin
            ph_now = pes_pkg::PH_0;
            move_now = regs.backward_speed;
          end
          default: begin
            ph_now = pes_pkg::PH_IDLE;
            move_now = '0;
            refused = 1'b1;
          end
        endcase
      end
      pes_pkg::OP_TICK: begin
        if (ph_now < pes_pkg::PH_IDLE) begin
          case (regs.space_kind)
            pes_pkg::KIND_LEFT_PERP:  perp_tick(1'b1, fin);
            pes_pkg::KIND_RIGHT_PERP: perp_tick(1'b0, fin);
            pes_pkg::KIND_LEFT_PAR:   par_tick(1'b1, fin);
            pes_pkg::KIND_RIGHT_PAR:  par_tick(1'b0, fin);
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    r.turn_cmd = steer_now;
    r.move_cmd = move_now;
    r.phase = ph_now;
    r.done_res = fin;
    r.bad_space = refused;
    return r;
  endfunction

  function automatic logic [15:0] pick_mm(input logic [15:0] dflt);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    if (r < 4) return dflt;
    return 16'($urandom_range(0, 8000));
  endfunction

  function automatic logic signed [15:0] pick_speed(input logic signed [15:0] dflt);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh8000;
    if (r == 1) return 16'sh7FFF;
    if (r < 4) return dflt;
    return 16'($urandom_range(0, 10000)) - 16'sd5000;
  endfunction

  task automatic send_beat(input logic [1:0] op, input logic [3:0] sel, input logic [15:0] mm,
                           input logic signed [15:0] spd, input logic [15:0] ticks);
    pes_pkg::item_t it;
    pes_pkg::res_t want;
    int unsigned gap, r;
    it.op = op;
    it.sensor_sel = sel;
    it.range_mm = mm;
    it.speed_mm_s = spd;
    it.elapsed_ticks = ticks;
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    want = advance_sequencer(it);
    pending_cmds.push_back(want);
    beats_sent++;
    if (want.done_res) exits_done++;
    if (want.bad_space) starts_refused++;
    r = $urandom_range(0, 99);
    if (calm || r < 55) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(4, 24);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // pipeline empty: safe to touch the registers
  task automatic drain();
    item_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input pes_pkg::cfg_t c, input logic [7:0] which);
    logic [15:0] v [8];
    v[pes_pkg::CFG_SPACE_KIND] = 16'(c.space_kind);
    v[pes_pkg::CFG_FORWARD_SPEED] = c.forward_speed;
    v[pes_pkg::CFG_BACKWARD_SPEED] = c.backward_speed;
    v[pes_pkg::CFG_EXIT_DISTANCE] = c.exit_distance;
    v[pes_pkg::CFG_SEARCH_DISTANCE] = c.search_distance;
    v[pes_pkg::CFG_BRAKE_DISTANCE] = c.brake_distance;
    v[pes_pkg::CFG_PARALLEL_CLEARANCE] = c.parallel_clearance;
    v[pes_pkg::CFG_SPACE_LENGTH] = c.space_length;
    for (int i = 0; i <= int'(pes_pkg::CFG_SPACE_LENGTH); i++) begin
      if (which[i]) begin
        cfg_we <= 1'b1;
        cfg_addr <= 3'(i);
        cfg_data <= v[i];
        @(posedge clk);
      end
    end
    cfg_we <= 1'b0;
    if (which[pes_pkg::CFG_SPACE_KIND]) regs.space_kind = c.space_kind;
    if (which[pes_pkg::CFG_FORWARD_SPEED]) regs.forward_speed = c.forward_speed;
    if (which[pes_pkg::CFG_BACKWARD_SPEED]) regs.backward_speed = c.backward_speed;
    if (which[pes_pkg::CFG_EXIT_DISTANCE]) regs.exit_distance = c.exit_distance;
    if (which[pes_pkg::CFG_SEARCH_DISTANCE]) regs.search_distance = c.search_distance;
    if (which[pes_pkg::CFG_BRAKE_DISTANCE]) regs.brake_distance = c.brake_distance;
    if (which[pes_pkg::CFG_PARALLEL_CLEARANCE])
      regs.parallel_clearance = c.parallel_clearance;
    if (which[pes_pkg::CFG_SPACE_LENGTH]) regs.space_length = c.space_length;
  endtask

  task automatic test_directed_edges();
    send_beat(pes_pkg::OP_TICK, pes_pkg::S_LF, 16'd0, 16'sd0, 16'd0);
    // still the unknown kind from reset
    send_beat(pes_pkg::OP_START, pes_pkg::S_LF, 16'd0, 16'sd0, 16'd0);
    send_beat(pes_pkg::OP_RANGE, pes_pkg::S_LF, 16'h0000, 16'sd0, 16'd0);
    send_beat(pes_pkg::OP_RANGE, pes_pkg::S_BR, 16'hFFFF, 16'sd0, 16'd0);
    send_beat(pes_pkg::OP_RANGE, pes_pkg::SENSOR_LIMIT, 16'hFFFF, 16'sd0, 16'd0);
    send_beat(pes_pkg::OP_RANGE, 4'hF, 16'h5A5A, 16'sd0, 16'd0);
    send_beat(pes_pkg::OP_SPEED, pes_pkg::S_LF, 16'd0, 16'sh7FFF, 16'hFFFF);
    send_beat(pes_pkg::OP_SPEED, pes_pkg::S_LF, 16'd0, 16'sh8000, 16'hFFFF);
    send_beat(pes_pkg::OP_SPEED, pes_pkg::S_LF, 16'd0, -16'sd1, 16'd1);
    send_beat(pes_pkg::OP_SPEED, pes_pkg::S_LF, 16'd0, 16'sd0, 16'hFFFF);
  endtask

  task automatic test_perp_exit();
    pes_pkg::cfg_t c;
    drain();
    c = regs;
    c.space_kind = pes_pkg::KIND_LEFT_PERP;
    program_regs(c, 8'h01 << pes_pkg::CFG_SPACE_KIND);
    send_beat(pes_pkg::OP_START, pes_pkg::S_LF, 16'd0, 16'sd0, 16'd0);
    send_beat(pes_pkg::OP_SPEED, pes_pkg::S_LF, 16'd0, 16'sd3000, 16'd1024);
    send_beat(pes_pkg::OP_TICK, pes_pkg::S_LF, 16'd0, 16'sd0, 16'd0);
    send_beat(pes_pkg::OP_RANGE, pes_pkg::S_RB, 16'hFFFF, 16'sd0, 16'd0);
    send_beat(pes_pkg::OP_TICK, pes_pkg::S_LF, 16'd0, 16'sd0, 16'd0);
    send_beat(pes_pkg::OP_RANGE, pes_pkg::S_LF, 16'hFFFF, 16'sd0, 16'd0);
    send_beat(pes_pkg::OP_RANGE, pes_pkg::S_LB, 16'd0, 16'sd0, 16'd0);
    send_beat(pes_pkg::OP_RANGE, pes_pkg::S_BCL, 16'd0, 16'sd0, 16'd0);
    // rear side too close: straighten
    send_beat(pes_pkg::OP_TICK, pes_pkg::S_LF, 16'd0, 16'sd0, 16'd0);
    send_beat(pes_pkg::OP_RANGE, pes_pkg::S_LB, 16'd300, 16'sd0, 16'd0);
    send_beat(pes_pkg::OP_TICK, pes_pkg::S_LF, 16'd0, 16'sd0, 16'd0);
    send_beat(pes_pkg::OP_RANGE, pes_pkg::S_LF, 16'd1499, 16'sd0, 16'd0);
    send_beat(pes_pkg::OP_TICK, pes_pkg::S_LF, 16'd0, 16'sd0, 16'd0);
  endtask

  task automatic test_parallel_entry();
    pes_pkg::cfg_t c;
    drain();
    c = regs;
    c.space_kind = pes_pkg::KIND_RIGHT_PAR;
    c.parallel_clearance = 16'd0;
    program_regs(c, (8'h01 << pes_pkg::CFG_SPACE_KIND) |
                    (8'h01 << pes_pkg::CFG_PARALLEL_CLEARANCE));
    send_beat(pes_pkg::OP_START, pes_pkg::S_LF, 16'd0, 16'sd0, 16'd0);
    send_beat(pes_pkg::OP_RANGE, pes_pkg::S_FCL, 16'd1, 16'sd0, 16'd0);
    send_beat(pes_pkg::OP_TICK, pes_pkg::S_LF, 16'd0, 16'sd0, 16'd0);
    // unknown kind while a maneuver is under way: tick holds, start is refused
    drain();
    c = regs;
    c.space_kind = pes_pkg::KIND_UNKNOWN;
    program_regs(c, 8'h01 << pes_pkg::CFG_SPACE_KIND);
    send_beat(pes_pkg::OP_TICK, pes_pkg::S_LF, 16'd0, 16'sd0, 16'd0);
    send_beat(pes_pkg::OP_START, pes_pkg::S_LF, 16'd0, 16'sd0, 16'd0);
  endtask

  task automatic test_odometer_saturation();
    pes_pkg::cfg_t c;
    drain();
    c = regs;
    c.space_kind = pes_pkg::KIND_LEFT_PERP;
    c.exit_distance = 16'hFFFF;
    program_regs(c, (8'h01 << pes_pkg::CFG_SPACE_KIND) |
                    (8'h01 << pes_pkg::CFG_EXIT_DISTANCE));
    send_beat(pes_pkg::OP_START, pes_pkg::S_LF, 16'd0, 16'sd0, 16'd0);
    repeat (1040)
      send_beat(pes_pkg::OP_SPEED, 4'($urandom), 16'($urandom), 16'sh7FFF, 16'hFFFF);
    // clamped high stays above the exit distance
    send_beat(pes_pkg::OP_TICK, pes_pkg::S_LF, 16'd0, 16'sd0, 16'd0);
  endtask

  task automatic test_random_exits();
    pes_pkg::cfg_t c;
    logic [7:0] which;
    logic first;
    logic [1:0] op;
    logic [3:0] sel;
    logic [15:0] mm, ticks, base;
    logic signed [15:0] spd;
    int unsigned counted, steps, r;
    counted = 0;
    first = 1'b1;
    while (counted < 560) begin
      drain();
      c = regs;
      c.space_kind = ($urandom_range(0, 9) == 0) ? pes_pkg::KIND_UNKNOWN
                                                 : 3'($urandom_range(0, 3));
      c.forward_speed = pick_speed(pes_pkg::RST_FORWARD_SPEED);
      c.backward_speed = pick_speed(pes_pkg::RST_BACKWARD_SPEED);
      c.exit_distance = pick_mm(pes_pkg::RST_EXIT_DISTANCE);
      c.search_distance = pick_mm(pes_pkg::RST_SEARCH_DISTANCE);
      c.brake_distance = pick_mm(pes_pkg::RST_BRAKE_DISTANCE);
      c.parallel_clearance = pick_mm(pes_pkg::RST_PARALLEL_CLEARANCE);
      c.space_length = pick_mm(pes_pkg::RST_SPACE_LENGTH);
      which = 8'($urandom);
      if ($urandom_range(0, 2) != 0) which[pes_pkg::CFG_SPACE_KIND] = 1'b1;
      if (first) which = '1;
      first = 1'b0;
      program_regs(c, which);
      calm = ($urandom_range(0, 5) == 0);
      // now and then keep the old phase so a kind change meets an active maneuver
      steps = $urandom_range(5, 60);
      if ($urandom_range(0, 9) != 0) begin
        send_beat(pes_pkg::OP_START, 4'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
        counted++;
      end
      while (steps != 0) begin
        steps--;
        op = 2'($urandom);
        sel = 4'($urandom);
        mm = 16'($urandom);
        spd = 16'($urandom);
        ticks = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 8) begin
          // fully random beat
        end else if (r < 50) begin
          op = pes_pkg::OP_RANGE;
          sel = 4'($urandom_range(0, pes_pkg::NUM_SENSORS - 1));
          case ($urandom_range(0, 6))
            0: base = regs.search_distance;
            1: base = regs.brake_distance;
            2: base = regs.parallel_clearance;
            3: base = regs.space_length;
            4: base = regs.space_length >> 1;
            5: base = pes_pkg::SPACE_WIDTH_MM;
            default: base = pes_pkg::MIN_SIDE_GAP_MM;
          endcase
          case ($urandom_range(0, 9))
            0: mm = 16'h0000;
            1: mm = 16'hFFFF;
            2, 3, 4: mm = 16'($urandom);
            default: mm = base + 16'($urandom_range(0, 2)) - 16'd1;
          endcase
        end else if (r < 65) begin
          op = pes_pkg::OP_SPEED;
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
              spd = 16'($urandom_range(0, 4000));
              ticks = 16'($urandom_range(0, 4096));
            end
            6, 7: begin
              spd = 16'sd0 - 16'($urandom_range(0, 4000));
              ticks = 16'($urandom_range(0, 4096));
            end
            default: ;
          endcase
        end else if (r < 97) begin
          op = pes_pkg::OP_TICK;
        end else begin
          op = pes_pkg::OP_START;
        end
        if (!(op == pes_pkg::OP_RANGE && sel >= pes_pkg::SENSOR_LIMIT) &&
            !(op == pes_pkg::OP_TICK && ph_now == pes_pkg::PH_IDLE))
          counted++;
        send_beat(op, sel, mm, spd, ticks);
        if (ph_now == pes_pkg::PH_IDLE && $urandom_range(0, 3) != 0) steps = 0;
      end
    end
    calm = 1'b0;
  endtask

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
      res_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      res_stall <= 1'b1;
      stall_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(3, 24) : $urandom_range(0, 2);
    end else begin
      res_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 30)
          $display("%0t: expected nothing, actual %0d/%0d/%0d/%0b/%0b", $realtime,
                   res.turn_cmd, res.move_cmd, res.phase, res.done_res, res.bad_space);
      end else begin
        oldest_cmd = pending_cmds.pop_front();
        beats_checked++;
        if (res.turn_cmd !== oldest_cmd.turn_cmd || res.move_cmd !== oldest_cmd.move_cmd ||
            res.phase !== oldest_cmd.phase || res.done_res !== oldest_cmd.done_res ||
            res.bad_space !== oldest_cmd.bad_space) begin
          mismatches++;
          if (mismatches <= 30)
            $display("%0t: turn/move/phase/done/bad expected %0d/%0d/%0d/%0b/%0b %s",
                     $realtime, oldest_cmd.turn_cmd, oldest_cmd.move_cmd, oldest_cmd.phase,
                     oldest_cmd.done_res, oldest_cmd.bad_space,
                     $sformatf("actual %0d/%0d/%0d/%0b/%0b", res.turn_cmd, res.move_cmd,
                               res.phase, res.done_res, res.bad_space));
        end
      end
    end
  end

  initial begin
    regs.space_kind = pes_pkg::RST_SPACE_KIND;
    regs.forward_speed = pes_pkg::RST_FORWARD_SPEED;
    regs.backward_speed = pes_pkg::RST_BACKWARD_SPEED;
    regs.exit_distance = pes_pkg::RST_EXIT_DISTANCE;
    regs.search_distance = pes_pkg::RST_SEARCH_DISTANCE;
    regs.brake_distance = pes_pkg::RST_BRAKE_DISTANCE;
    regs.parallel_clearance = pes_pkg::RST_PARALLEL_CLEARANCE;
    regs.space_length = pes_pkg::RST_SPACE_LENGTH;
    foreach (ranges[i]) ranges[i] = '0;
    odometer = '0;
    ph_now = pes_pkg::PH_IDLE;
    steer_now = pes_pkg::T_STRAIGHT;
    move_now = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_perp_exit();
    test_parallel_entry();
    test_odometer_saturation();
    test_random_exits();
    drain();
    $display("run covered %0d input beats and %0d checked result beats", beats_sent,
             beats_checked);
    $display("%0d exits ran to completion, %0d starts were refused for an unknown space",
             exits_done, starts_refused);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d result beats outstanding", pending_cmds.size());
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/pes_pkg.sv
src/pes_cfg.sv
src/pes_step.sv
src/parking_exit_sequencer_core.sv
bench/tb_top.sv
